// File: sv/pbsp_pkg.sv
package pbsp_pkg;

  // Fixed field widths of the request and result streams.
  localparam int unsigned PAGE_FIELD_W = 32;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned VP_W         = 5;
  localparam int unsigned SLOT_OUT_W   = 4;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned IN_DATA_W    = 64;
  localparam int unsigned OUT_DATA_W   = 72;

  localparam logic [CFG_W-1:0] NUM_SLOTS_RESET = 5'd4;
  localparam logic [VP_W-1:0]  VP_RESET        = 5'd1;
  localparam logic [VP_W-1:0]  VP_WRAP         = 5'd2;

  localparam logic OP_READ      = 1'b0;
  localparam logic OP_OVERWRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

endpackage

// File: sv/page_buffer_slot_policy.sv
// Slot bookkeeping for a small page buffer.
// Requests enter on the s_ stream: s_tuser is the operation (read or
// overwrite check), s_tdata carries the page number and the current root
// page. Each request gives exactly one result on the m_ stream with the
// slot, hit and fetch flags and the running hit and storage read counts.
// The slot table lives in a one-port-read, one-port-write memory that is
// scanned one slot per cycle. With n the slot count (num_slots held to
// 2..MAX_SLOTS), a request passes these steps: one read per slot 1..n-1,
// the last compare, the choice of slot, then the write-back and the load
// of the output register. s_tready returns in the cycle the result turns
// valid, so no new request is taken before the last result is loaded.
// If the receiver stalls, the result is held in the output register; the
// next request is still taken and scanned, but it waits before writing
// back and keeps s_tready low until the output register frees up.
// Reset empties every slot, clears both counters and the last hit page,
// sets the round-robin pointer to one and num_slots to four. The user must
// write num_slots through cfg_we/cfg_wdata only while idle; it is not enforced.
module page_buffer_slot_policy #(
  parameter int unsigned MAX_SLOTS    = 16,
  parameter int unsigned PAGE_ID_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pbsp_pkg::CFG_W-1:0]         cfg_wdata,   // num_slots
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pbsp_pkg::IN_DATA_W-1:0]     s_tdata,     // page_id, root_page
  input  logic                               s_tuser,     // op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pbsp_pkg::OUT_DATA_W-1:0]    m_tdata      // slot, hit, fetch,
                                                          // hit_count, read_count
);

  import pbsp_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned NW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = (NW > CFG_W) ? NW : CFG_W;

  state_t                  state;
  logic [CFG_W-1:0]        num_slots;
  logic                    op_q;
  logic [PAGE_ID_BITS-1:0] page_q;
  logic [PAGE_ID_BITS-1:0] root_q;
  logic [SW-1:0]           nm1;
  logic [SW-1:0]           nm1_next;
  logic [CW-1:0]           n_sat;
  logic                    issue_on;
  logic [SW-1:0]           issue_idx;
  logic                    rd_vld;
  logic [SW-1:0]           rd_idx;
  logic [PAGE_ID_BITS-1:0] rd_page;
  logic [MAX_SLOTS-1:0]    match_vec;
  logic [MAX_SLOTS-1:0]    empty_vec;
  logic [MAX_SLOTS-1:0]    lh_vec;
  logic [PAGE_ID_BITS-1:0] last_hit_page;
  logic [VP_W-1:0]         vp;
  logic [COUNT_W-1:0]      hits;
  logic [COUNT_W-1:0]      reads;
  logic [SW-1:0]           res_slot;
  logic                    res_hit;
  logic                    res_fetch;
  logic [SW-1:0]           m_slot;
  logic                    m_hit;
  logic                    m_fetch;
  logic [COUNT_W-1:0]      m_hits;
  logic [COUNT_W-1:0]      m_reads;
  logic                    out_free;
  logic                    accept;
  logic                    mem_rd_en;
  logic                    mem_wr_en;

  // Decision signals.
  logic [MAX_SLOTS-1:0]    in_range;
  logic                    hit_found;
  logic [SW-1:0]           hit_slot;
  logic                    empty_found;
  logic [SW-1:0]           empty_slot;
  logic                    vp_wrapped;
  logic [SW-1:0]           rr_start;
  logic [VP_W-1:0]         vp_step;
  logic                    cand1_found;
  logic [SW-1:0]           cand1;
  logic                    cand2_found;
  logic [SW-1:0]           cand2;
  logic [SW-1:0]           rr_slot;
  logic [VP_W-1:0]         rr_vp;
  logic                    dec_hit;
  logic                    dec_fetch;
  logic                    dec_rr;
  logic [SW-1:0]           dec_slot;
  logic [SLOT_OUT_W+SW-1:0] slot_ext;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    n_sat = CW'(num_slots);
    if (n_sat < CW'(2)) begin
      n_sat = CW'(2);
    end else if (n_sat > CW'(MAX_SLOTS)) begin
      n_sat = CW'(MAX_SLOTS);
    end
    nm1_next = SW'(n_sat - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots <= NUM_SLOTS_RESET;
    end else if (cfg_we) begin
      num_slots <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_tuser;
      page_q <= s_tdata[PAGE_ID_BITS-1:0];
      root_q <= s_tdata[PAGE_FIELD_W +: PAGE_ID_BITS];
      nm1    <= nm1_next;
    end
  end

  // Slot table: read one slot per cycle while scanning, write on a read miss.
  assign mem_rd_en = (state == ST_SCAN) && issue_on;
  assign mem_wr_en = (state == ST_OUT) && out_free && res_fetch;

  pbsp_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .DW    (PAGE_ID_BITS),
    .AW    (SW)
  ) u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (issue_idx),
    .rd_data (rd_page),
    .wr_en   (mem_wr_en),
    .wr_addr (res_slot),
    .wr_data (page_q)
  );

  // Compare results land in per-slot flag vectors. Bits outside 1..n-1
  // are stale and are masked off by in_range.
  always_ff @(posedge clk) begin
    rd_idx <= issue_idx;
    if (rd_vld) begin
      match_vec[rd_idx] <= (rd_page == page_q) && (page_q != '0);
      empty_vec[rd_idx] <= (rd_page == '0);
      lh_vec[rd_idx]    <= (rd_page == last_hit_page);
    end
  end

  always_comb begin
    in_range    = '0;
    hit_found   = 1'b0;
    hit_slot    = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    cand1_found = 1'b0;
    cand1       = '0;
    cand2_found = 1'b0;
    cand2       = '0;
    vp_wrapped  = (CW'(vp) > CW'(nm1));
    rr_start    = vp_wrapped ? SW'(2) : SW'(vp);
    vp_step     = vp_wrapped ? VP_WRAP : VP_W'(vp + 1'b1);
    for (int i = MAX_SLOTS - 1; i >= 1; i--) begin
      in_range[i] = (SW'(i) <= nm1);
    end
    // Scanning downward leaves the lowest qualifying slot in each search.
    for (int i = MAX_SLOTS - 1; i >= 1; i--) begin
      if (in_range[i] && match_vec[i]) begin
        hit_found = 1'b1;
        hit_slot  = SW'(i);
      end
      if (in_range[i] && empty_vec[i] && (i >= 2)) begin
        empty_found = 1'b1;
        empty_slot  = SW'(i);
      end
      if (in_range[i] && !lh_vec[i] && (SW'(i) >= rr_start)) begin
        cand1_found = 1'b1;
        cand1       = SW'(i);
      end
      if (in_range[i] && !lh_vec[i] && (i >= 2)) begin
        cand2_found = 1'b1;
        cand2       = SW'(i);
      end
    end
    // Round robin: from the pointer up, then once more from slot 2; when
    // every candidate holds the last hit page the first candidate is used.
    if (cand1_found) begin
      rr_slot = cand1;
      rr_vp   = vp_step;
    end else if (cand2_found) begin
      rr_slot = cand2;
      rr_vp   = VP_WRAP;
    end else begin
      rr_slot = rr_start;
      rr_vp   = VP_WRAP;
    end
  end

  always_comb begin
    dec_hit   = hit_found;
    dec_fetch = 1'b0;
    dec_rr    = 1'b0;
    dec_slot  = hit_slot;
    if (op_q == OP_READ && !hit_found) begin
      dec_fetch = 1'b1;
      if (nm1 == SW'(1) || page_q == root_q) begin
        dec_slot = SW'(1);
      end else if (nm1 == SW'(2)) begin
        dec_slot = SW'(2);
      end else if (empty_found) begin
        dec_slot = empty_slot;
      end else begin
        dec_slot = rr_slot;
        dec_rr   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      res_slot  <= dec_slot;
      res_hit   <= dec_hit;
      res_fetch <= dec_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      issue_on      <= 1'b0;
      issue_idx     <= '0;
      rd_vld        <= 1'b0;
      last_hit_page <= '0;
      vp            <= VP_RESET;
      hits          <= '0;
      reads         <= '0;
    end else begin
      rd_vld <= mem_rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_SCAN;
            issue_on  <= 1'b1;
            issue_idx <= SW'(1);
          end
        end
        ST_SCAN: begin
          if (mem_rd_en) begin
            if (issue_idx == nm1) begin
              issue_on <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (rd_vld && rd_idx == nm1) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (op_q == OP_READ && hit_found) begin
            hits          <= hits + 1'b1;
            last_hit_page <= page_q;
          end
          if (dec_fetch) begin
            reads <= reads + 1'b1;
          end
          if (dec_rr) begin
            vp <= rr_vp;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_slot  <= res_slot;
      m_hit   <= res_hit;
      m_fetch <= res_fetch;
      m_hits  <= hits;
      m_reads <= reads;
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, m_slot};
  assign m_tdata  = {2'b00, m_reads, m_hits, m_fetch, m_hit,
                     slot_ext[SLOT_OUT_W-1:0]};

  // A compare result always belongs to a slot inside the scanned range.
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (rd_idx != '0) && (rd_idx <= nm1))
    else $error("slot compare outside scanned range");

  // A hit and a fetch never come together, and a fetch never targets slot 0.
  a_res_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !(res_hit && res_fetch) && !(res_fetch && res_slot == '0))
    else $error("inconsistent slot decision");

  // Each table write goes with a result loaded into the output register.
  a_wr_with_result: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |=> m_tvalid && m_fetch)
    else $error("slot write without matching result");

  // The hit counter only ever steps by one.
  a_hits_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && hits != $past(hits)) |-> (hits == $past(hits) + 1'b1))
    else $error("hit counter jumped");

endmodule

// File: sv/pbsp_slot_mem.sv
module pbsp_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as an empty slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule
